// File: src/wfsa_pkg.sv
// package for the weighted film splat accumulator: constants, word types, blend function
package wfsa_pkg;

  // film geometry and splat limit
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_SPLAT  = 8;
  localparam int unsigned NUM_CH     = 3;

  // field widths
  localparam int unsigned RES_W   = 9;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned CH_W    = 24;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned PROD_W  = CH_W + WGT_W;
  localparam int unsigned ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  // operation codes
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RES_WIDTH  = 1'b0,
    REG_RES_HEIGHT = 1'b1
  } cfg_reg_e;

  // control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLAT,
    ST_DRAIN,
    ST_READ,
    ST_RDATA
  } state_e;

  // one film pixel, channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  // input word
  typedef struct packed {
    logic              operation;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] splat_size;
    logic [CH_W-1:0]   color_red;
    logic [CH_W-1:0]   color_green;
    logic [CH_W-1:0]   color_blue;
    logic [WGT_W-1:0]  new_weight;
    logic [WGT_W-1:0]  old_weight;
  } in_word_t;

  // result word
  typedef struct packed {
    logic            is_read_data;
    logic            out_of_range;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;
  } out_word_t;

  // sum two weighted products, drop the fraction, saturate to the channel range
  function automatic logic [CH_W-1:0] blend_sat(logic [PROD_W-1:0] a, logic [PROD_W-1:0] b);
    logic [PROD_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[PROD_W:CH_W+FRAC_W] != '0) begin
      return CH_MAX;
    end
    return sum[CH_W+FRAC_W-1:FRAC_W];
  endfunction

endpackage

// File: src/weighted_film_splat_accumulator_core.sv
// top level: film store with weighted splat read-modify-write and pixel read
//
// channel   direction  handshake              payload
// item      in         start / busy           in_i (wfsa_pkg::in_word_t)
// result    out        done_o strobe          result_o (wfsa_pkg::out_word_t)
// config    in         cfg_we_i, cfg_idx_i    cfg_wdata_i (9 bits)
//
// an accumulate steps through the clamp(splat_size)^2 splat pixels, writing those in range, then
// drains the write pipeline before done_o (a zero size goes straight to the drain); a read passes ST_READ, ST_RDATA
// the film memory does one pixel read-modify-write per cycle, three channels side by side
// after reset busy stays high for a clearing pass over all 65536 pixels, one pixel per cycle
// done_o is high for one cycle and cannot be held off; a new item may start in that cycle

module weighted_film_splat_accumulator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  wfsa_pkg::in_word_t               in_i,
  output logic                             done_o,
  output wfsa_pkg::out_word_t              result_o,
  input  logic                             cfg_we_i,
  input  logic [wfsa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wfsa_pkg::RES_W-1:0]       cfg_wdata_i
);

  wfsa_pkg::state_e state_q, state_d;

  logic [wfsa_pkg::RES_W-1:0]  res_width_q, res_height_q;
  logic [wfsa_pkg::RES_W-1:0]  w_eff, h_eff;
  logic [wfsa_pkg::ADDR_W-1:0] clr_cnt_q;
  wfsa_pkg::in_word_t          item_q;
  logic [wfsa_pkg::SIZE_W-1:0] size_q, size_clamp;
  logic [wfsa_pkg::SIZE_W-1:0] i_q, j_q;
  logic                        last_i, last_j;

  logic [wfsa_pkg::RES_W-1:0]   cur_x, cur_y;
  logic [2*wfsa_pkg::RES_W-1:0] row_base, addr_full;
  logic [wfsa_pkg::ADDR_W-1:0]  cur_addr;
  logic                         in_range;

  logic                         accept;
  logic                         clr_active, splat_issue, drain_done, rdata_done;

  logic                         p1_valid_q, p2_valid_q;
  logic [wfsa_pkg::ADDR_W-1:0]  p1_addr_q, p2_addr_q;
  logic                         rd_oor_q;
  wfsa_pkg::pix_t               rd_data_q;
  wfsa_pkg::pix_t               col_pix;
  logic [wfsa_pkg::NUM_CH-1:0][wfsa_pkg::PROD_W-1:0] old_prod_q, new_prod_q;

  logic                         mem_we;
  logic [wfsa_pkg::ADDR_W-1:0]  mem_waddr;
  wfsa_pkg::pix_t               mem_wdata, blend_pix;
  wfsa_pkg::pix_t               film_mem [wfsa_pkg::DEPTH];

  logic                         out_valid_q;
  wfsa_pkg::out_word_t          out_q;

  // effective resolution, clamped to the film size
  assign w_eff = (res_width_q > wfsa_pkg::RES_W'(wfsa_pkg::MAX_WIDTH))
                 ? wfsa_pkg::RES_W'(wfsa_pkg::MAX_WIDTH) : res_width_q;
  assign h_eff = (res_height_q > wfsa_pkg::RES_W'(wfsa_pkg::MAX_HEIGHT))
                 ? wfsa_pkg::RES_W'(wfsa_pkg::MAX_HEIGHT) : res_height_q;

  assign size_clamp = (in_i.splat_size > wfsa_pkg::SIZE_W'(wfsa_pkg::MAX_SPLAT))
                      ? wfsa_pkg::SIZE_W'(wfsa_pkg::MAX_SPLAT) : in_i.splat_size;

  assign accept = start && !busy;

  // current pixel position and its film address
  assign cur_x     = wfsa_pkg::RES_W'(item_q.pos_x) + wfsa_pkg::RES_W'(i_q);
  assign cur_y     = wfsa_pkg::RES_W'(item_q.pos_y) + wfsa_pkg::RES_W'(j_q);
  assign in_range  = (cur_x < w_eff) && (cur_y < h_eff);
  assign row_base  = cur_y * w_eff;
  assign addr_full = row_base + (2*wfsa_pkg::RES_W)'(cur_x);
  assign cur_addr  = addr_full[wfsa_pkg::ADDR_W-1:0];

  assign last_i = (i_q == wfsa_pkg::SIZE_W'(size_q - wfsa_pkg::SIZE_W'(1)));
  assign last_j = (j_q == wfsa_pkg::SIZE_W'(size_q - wfsa_pkg::SIZE_W'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wfsa_pkg::ST_CLEAR: begin
        if (clr_cnt_q == wfsa_pkg::ADDR_W'(wfsa_pkg::DEPTH - 1)) state_d = wfsa_pkg::ST_IDLE;
      end
      wfsa_pkg::ST_IDLE: begin
        if (start) begin
          if (in_i.operation == wfsa_pkg::OP_READ) begin
            state_d = wfsa_pkg::ST_READ;
          end else if (size_clamp == '0) begin
            state_d = wfsa_pkg::ST_DRAIN;
          end else begin
            state_d = wfsa_pkg::ST_SPLAT;
          end
        end
      end
      wfsa_pkg::ST_SPLAT: begin
        if (last_i && last_j) state_d = wfsa_pkg::ST_DRAIN;
      end
      wfsa_pkg::ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) state_d = wfsa_pkg::ST_IDLE;
      end
      wfsa_pkg::ST_READ:  state_d = wfsa_pkg::ST_RDATA;
      wfsa_pkg::ST_RDATA: state_d = wfsa_pkg::ST_IDLE;
      default:            state_d = wfsa_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy        = (state_q != wfsa_pkg::ST_IDLE);
    clr_active  = (state_q == wfsa_pkg::ST_CLEAR);
    splat_issue = (state_q == wfsa_pkg::ST_SPLAT) && in_range;
    drain_done  = (state_q == wfsa_pkg::ST_DRAIN) && !p1_valid_q && !p2_valid_q;
    rdata_done  = (state_q == wfsa_pkg::ST_RDATA);
  end

  // state, clear counter and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wfsa_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      res_width_q  <= wfsa_pkg::RES_W'(256);
      res_height_q <= wfsa_pkg::RES_W'(256);
    end else begin
      state_q <= state_d;
      if (clr_active) clr_cnt_q <= clr_cnt_q + wfsa_pkg::ADDR_W'(1);
      if (cfg_we_i) begin
        unique case (wfsa_pkg::cfg_reg_e'(cfg_idx_i))
          wfsa_pkg::REG_RES_WIDTH:  res_width_q  <= cfg_wdata_i;
          wfsa_pkg::REG_RES_HEIGHT: res_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // item latch and splat pixel counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      size_q <= '0;
    end else if (accept) begin
      i_q    <= '0;
      j_q    <= '0;
      size_q <= size_clamp;
    end else if (state_q == wfsa_pkg::ST_SPLAT) begin
      if (last_i) begin
        i_q <= '0;
        j_q <= j_q + wfsa_pkg::SIZE_W'(1);
      end else begin
        i_q <= i_q + wfsa_pkg::SIZE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i;
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= splat_issue;
      p2_valid_q <= p1_valid_q;
    end
  end

  // pipeline payload: address hand-off and weighted products
  assign col_pix = {item_q.color_blue, item_q.color_green, item_q.color_red};

  always_ff @(posedge clk_i) begin
    p1_addr_q <= cur_addr;
    p2_addr_q <= p1_addr_q;
    if (state_q == wfsa_pkg::ST_READ) rd_oor_q <= !in_range;
    for (int c = 0; c < wfsa_pkg::NUM_CH; c++) begin
      old_prod_q[c] <= wfsa_pkg::PROD_W'(rd_data_q[c])
                       * wfsa_pkg::PROD_W'(item_q.old_weight);
      new_prod_q[c] <= wfsa_pkg::PROD_W'(col_pix[c])
                       * wfsa_pkg::PROD_W'(item_q.new_weight);
    end
  end

  // sum, scale and saturate each channel
  always_comb begin
    for (int c = 0; c < wfsa_pkg::NUM_CH; c++) begin
      blend_pix[c] = wfsa_pkg::blend_sat(old_prod_q[c], new_prod_q[c]);
    end
  end

  // write port: clearing pass or blended pixel
  assign mem_we    = clr_active || p2_valid_q;
  assign mem_waddr = clr_active ? clr_cnt_q : p2_addr_q;
  assign mem_wdata = clr_active ? '0 : blend_pix;

  // film memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) film_mem[mem_waddr] <= mem_wdata;
    rd_data_q <= film_mem[cur_addr];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= drain_done || rdata_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_done) begin
      out_q <= '0;
    end else if (rdata_done) begin
      out_q.is_read_data <= 1'b1;
      out_q.out_of_range <= rd_oor_q;
      out_q.pixel_red    <= rd_oor_q ? '0 : rd_data_q[0];
      out_q.pixel_green  <= rd_oor_q ? '0 : rd_data_q[1];
      out_q.pixel_blue   <= rd_oor_q ? '0 : rd_data_q[2];
    end
  end

  assign done_o   = out_valid_q;
  assign result_o = out_q;

`ifndef ASSERT_OFF
  // a result word only follows the end of a splat drain or a pixel read
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == wfsa_pkg::ST_DRAIN || $past(state_q) == wfsa_pkg::ST_RDATA))
    else $error("result without finished item");

  // every accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // no film write may still be pending once the block is idle
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wfsa_pkg::ST_IDLE) |-> (!mem_we && !p1_valid_q))
    else $error("film write outstanding while idle");

  // clearing pass and blend writes never overlap
  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active |-> !p2_valid_q)
    else $error("blend write during clearing pass");
`endif

endmodule
